### hdl/assert_macros.svh
// assertion helpers used by rmts_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// implication checked at every rising clock edge out of reset
`define RMTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rmts assertion failed");
// next-cycle implication checked out of reset
`define RMTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rmts assertion failed");
`else
`define RMTS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RMTS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### hdl/rmts_pkg.sv
package rmts_pkg;

  localparam int MAX_TASKS_DEF = 8;

  // input commands
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // result kinds
  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_STATS   = 1'b1;

  // segment outcomes
  localparam logic [1:0] OUT_NONE      = 2'd0;
  localparam logic [1:0] OUT_FINISHED  = 2'd1;
  localparam logic [1:0] OUT_LOST      = 2'd2;
  localparam logic [1:0] OUT_PREEMPTED = 2'd3;

  // configuration register indexes
  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // write table entry from input
    logic tick_start; // clear chosen candidate
    logic sweep;      // deadline, release, candidate at entry
    logic sel_run;    // index running task
    logic sel_chosen; // index chosen task
    logic emit_seg;   // emit tick segment
    logic run;        // commit choice, run one tick, advance time
    logic emit_fseg;  // emit final segment
    logic emit_rec;   // emit statistics record
    logic rec_last;   // mark result as last
    logic clear;      // clear entry
    logic clear_run;  // clear time and running task
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic seg_need;
  } dp_stat_t;

endpackage

### hdl/rmts_if.sv
// input item channel
interface rmts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  task_slot;
  logic [15:0] task_period;
  logic [15:0] task_burst;
  logic [15:0] task_deadline;
  logic [7:0]  task_order;
  modport source (output valid, command, task_slot, task_period, task_burst,
                  task_deadline, task_order, input ready);
  modport sink (input valid, command, task_slot, task_period, task_burst,
                task_deadline, task_order, output ready);
endinterface

// result item channel
interface rmts_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [2:0]  task_id;
  logic        idle;
  logic [31:0] duration;
  logic [1:0]  outcome;
  logic [31:0] completed_count;
  logic [31:0] lost_count;
  logic        killed_count;
  logic        last;
  modport source (output valid, result_kind, task_id, idle, duration, outcome,
                  completed_count, lost_count, killed_count, last, input ready);
  modport sink (input valid, result_kind, task_id, idle, duration, outcome,
                completed_count, lost_count, killed_count, last, output ready);
endinterface

### hdl/rmts_ctrl.sv
`include "assert_macros.svh"

module rmts_ctrl #(
  parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEF,
  localparam int CNT_W = $clog2(MAX_TASKS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [3:0]         task_count,
  input  rmts_pkg::dp_stat_t stat,
  output rmts_pkg::dp_cmd_t  cmd,
  output logic [CNT_W-1:0]   cnt
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_TDEC  = 3'd2;
  localparam logic [2:0] S_TRUN  = 3'd3;
  localparam logic [2:0] S_FSEG  = 3'd4;
  localparam logic [2:0] S_FREC  = 3'd5;
  localparam logic [2:0] S_CLR   = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] n_use;
  logic             in_xfer;

  // entries in use
  assign n_use = (32'(task_count) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : CNT_W'(task_count);
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer = in_valid && in_ready;
  assign cnt = cnt_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cnt_nxt = '0;
          case (in_command)
            rmts_pkg::CMD_LOAD: cmd.load = 1'b1;
            rmts_pkg::CMD_TICK: begin
              cmd.tick_start = 1'b1;
              state_nxt = (n_use == '0) ? S_TDEC : S_SWEEP;
            end
            rmts_pkg::CMD_FINISH: state_nxt = S_FSEG;
            default: ;
          endcase
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r + 1'b1 == n_use) state_nxt = S_TDEC;
      end
      S_TDEC: begin
        cmd.sel_run = 1'b1;
        if (!stat.seg_need) begin
          state_nxt = S_TRUN;
        end else if (stat.out_free) begin
          cmd.emit_seg = 1'b1;
          state_nxt = S_TRUN;
        end
      end
      S_TRUN: begin
        cmd.sel_chosen = 1'b1;
        cmd.run = 1'b1;
        state_nxt = S_IDLE;
      end
      S_FSEG: begin
        cmd.sel_run = 1'b1;
        if (stat.out_free) begin
          cmd.emit_fseg = 1'b1;
          cmd.rec_last = (n_use == '0);
          cnt_nxt = '0;
          state_nxt = (n_use == '0) ? S_CLR : S_FREC;
        end
      end
      S_FREC: begin
        if (stat.out_free) begin
          cmd.emit_rec = 1'b1;
          cmd.rec_last = (cnt_r + 1'b1 == n_use);
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r + 1'b1 == n_use) begin
            cnt_nxt = '0;
            state_nxt = S_CLR;
          end
        end
      end
      S_CLR: begin
        cmd.clear = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAX_TASKS - 1)) begin
          cmd.clear_run = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `RMTS_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit_seg || cmd.emit_fseg || cmd.emit_rec, stat.out_free)
  `RMTS_ASSERT_IMP(a_sweep_range, clk, rst_n, state_r == S_SWEEP, cnt_r < n_use)
  `RMTS_ASSERT_NXT(a_tick_start, clk, rst_n, in_xfer && in_command == rmts_pkg::CMD_TICK, state_r == S_SWEEP || state_r == S_TDEC)

endmodule

### hdl/rmts_dp.sv
module rmts_dp #(
  parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEF,
  localparam int CNT_W = $clog2(MAX_TASKS + 1),
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rmts_pkg::dp_cmd_t  cmd,
  output rmts_pkg::dp_stat_t stat,
  input  logic [CNT_W-1:0]   cnt,
  input  logic               algorithm_mode,
  input  logic [2:0]         ld_slot,
  input  logic [15:0]        ld_period,
  input  logic [15:0]        ld_burst,
  input  logic [15:0]        ld_deadline,
  input  logic [7:0]         ld_order,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_result_kind,
  output logic [2:0]         out_task_id,
  output logic               out_idle,
  output logic [31:0]        out_duration,
  output logic [1:0]         out_outcome,
  output logic [31:0]        out_completed_count,
  output logic [31:0]        out_lost_count,
  output logic               out_killed_count,
  output logic               out_last
);

  localparam logic [31:0] SAT = '1;

  // task table, undefined until loaded
  logic [15:0] tp_r [MAX_TASKS];
  logic [15:0] tb_r [MAX_TASKS];
  logic [15:0] td_r [MAX_TASKS];
  logic [7:0]  to_r [MAX_TASKS];
  // job state
  logic        act_r  [MAX_TASKS];
  logic [15:0] rem_r  [MAX_TASKS];
  logic [31:0] due_r  [MAX_TASKS];
  logic [15:0] ttr_r  [MAX_TASKS];
  logic [31:0] done_r [MAX_TASKS];
  logic [31:0] miss_r [MAX_TASKS];

  logic [31:0]      time_r, segb_r;
  logic             run_v_r;
  logic [IDX_W-1:0] run_idx_r;
  logic             ch_v_r;
  logic [IDX_W-1:0] ch_idx_r;
  logic [15:0]      best_p_r;
  logic [7:0]       best_o_r;

  logic             out_valid_r;
  logic             kind_r, idle_r, killed_r, last_r;
  logic [2:0]       id_r;
  logic [31:0]      dur_r, comp_r, lost_r;
  logic [1:0]       outc_r;

  logic [IDX_W-1:0] idx;
  logic             drop, rel, act1, act2, cand, better, differ;
  logic [15:0]      rem2, ttr2;
  logic [31:0]      due2, miss1;
  logic [1:0]       tick_outc, fin_outc;
  logic             emit;

  // entry select
  always_comb begin
    if (cmd.sel_run) idx = run_idx_r;
    else if (cmd.sel_chosen) idx = ch_idx_r;
    else idx = cnt[IDX_W-1:0];
  end

  // deadline drop and release at the selected entry
  assign drop = act_r[idx] && (rem_r[idx] != '0) && (due_r[idx] == time_r);
  assign act1 = drop ? 1'b0 : act_r[idx];
  assign miss1 = (drop && miss_r[idx] != SAT) ? miss_r[idx] + 1'b1 : miss_r[idx];
  assign rel = (ttr_r[idx] == '0);
  assign act2 = rel ? 1'b1 : act1;
  assign rem2 = rel ? tb_r[idx] : rem_r[idx];
  assign due2 = rel ? time_r + {16'd0, td_r[idx]} : due_r[idx];
  assign ttr2 = rel ? ((tp_r[idx] == '0) ? 16'd0 : tp_r[idx] - 1'b1) : ttr_r[idx] - 1'b1;

  // rate monotonic candidate compare
  assign cand = !algorithm_mode && act2 && (rem2 != '0);
  assign better = !ch_v_r || (tp_r[idx] < best_p_r) ||
                  ((tp_r[idx] == best_p_r) && (to_r[idx] < best_o_r));

  assign differ = (ch_v_r != run_v_r) || (ch_v_r && (ch_idx_r != run_idx_r));
  assign stat.seg_need = differ && (time_r != segb_r);
  assign stat.out_free = !out_valid_r || out_ready;

  // segment outcomes from running task entry
  always_comb begin
    if (!run_v_r) tick_outc = rmts_pkg::OUT_NONE;
    else if (!act_r[idx]) tick_outc = (rem_r[idx] == '0) ? rmts_pkg::OUT_FINISHED
                                                        : rmts_pkg::OUT_LOST;
    else tick_outc = rmts_pkg::OUT_PREEMPTED;
  end
  assign fin_outc = (run_v_r && !act_r[idx] && rem_r[idx] == '0) ? rmts_pkg::OUT_FINISHED
                                                                : rmts_pkg::OUT_NONE;

  // task table load
  always_ff @(posedge clk) begin
    if (cmd.load && 32'(ld_slot) < MAX_TASKS) begin
      tp_r[IDX_W'(ld_slot)] <= ld_period;
      tb_r[IDX_W'(ld_slot)] <= ld_burst;
      td_r[IDX_W'(ld_slot)] <= ld_deadline;
      to_r[IDX_W'(ld_slot)] <= ld_order;
    end
  end

  // job state per entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        act_r[i] <= 1'b0;
        rem_r[i] <= '0;
        due_r[i] <= '0;
        ttr_r[i] <= '0;
        done_r[i] <= '0;
        miss_r[i] <= '0;
      end
    end else if (cmd.sweep) begin
      act_r[idx] <= act2;
      rem_r[idx] <= rem2;
      due_r[idx] <= due2;
      ttr_r[idx] <= ttr2;
      miss_r[idx] <= miss1;
    end else if (cmd.run && ch_v_r) begin
      rem_r[idx] <= rem_r[idx] - 1'b1;
      if (rem_r[idx] == 16'd1) begin
        act_r[idx] <= 1'b0;
        if (done_r[idx] != SAT) done_r[idx] <= done_r[idx] + 1'b1;
      end
    end else if (cmd.clear) begin
      act_r[idx] <= 1'b0;
      rem_r[idx] <= '0;
      due_r[idx] <= '0;
      ttr_r[idx] <= '0;
      done_r[idx] <= '0;
      miss_r[idx] <= '0;
    end
  end

  // time, running task and chosen candidate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
      segb_r <= '0;
      run_v_r <= 1'b0;
      run_idx_r <= '0;
      ch_v_r <= 1'b0;
      ch_idx_r <= '0;
      best_p_r <= '0;
      best_o_r <= '0;
    end else begin
      if (cmd.tick_start) ch_v_r <= 1'b0;
      if (cmd.sweep && cand && better) begin
        ch_v_r <= 1'b1;
        ch_idx_r <= idx;
        best_p_r <= tp_r[idx];
        best_o_r <= to_r[idx];
      end
      if (cmd.run) begin
        if (differ) begin
          run_v_r <= ch_v_r;
          run_idx_r <= ch_idx_r;
          segb_r <= time_r;
        end
        time_r <= time_r + 1'b1;
      end
      if (cmd.clear_run) begin
        time_r <= '0;
        segb_r <= '0;
        run_v_r <= 1'b0;
      end
    end
  end

  // output register
  assign emit = cmd.emit_seg || cmd.emit_fseg || cmd.emit_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      last_r <= cmd.rec_last;
      if (cmd.emit_rec) begin
        kind_r <= rmts_pkg::KIND_STATS;
        id_r <= 3'(idx);
        idle_r <= 1'b0;
        dur_r <= '0;
        outc_r <= rmts_pkg::OUT_NONE;
        comp_r <= done_r[idx];
        lost_r <= miss_r[idx];
        killed_r <= act_r[idx] && (rem_r[idx] != '0);
      end else begin
        kind_r <= rmts_pkg::KIND_SEGMENT;
        id_r <= run_v_r ? 3'(run_idx_r) : 3'd0;
        idle_r <= !run_v_r;
        dur_r <= time_r - segb_r;
        outc_r <= cmd.emit_fseg ? fin_outc : tick_outc;
        comp_r <= '0;
        lost_r <= '0;
        killed_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_task_id = id_r;
  assign out_idle = idle_r;
  assign out_duration = dur_r;
  assign out_outcome = outc_r;
  assign out_completed_count = comp_r;
  assign out_lost_count = lost_r;
  assign out_killed_count = killed_r;
  assign out_last = last_r;

endmodule

### hdl/rate_monotonic_tick_scheduler_top.sv
// channel  dir  payload
// in_ch    in   command, task_slot, task_period, task_burst, task_deadline, task_order
// out_ch   out  result_kind, task_id, idle, duration, outcome, counts, killed, last
// cfg      in   cfg_we, cfg_addr (0 mode, 1 task count), cfg_wdata
//
// load: the table entry is written as the item is taken. tick (n = entries in use): a
// sweep at one entry per cycle, a segment step that waits on a full output, a run step.
// finish: n + 1 result transfers, then a clearing pass over all MAX_TASKS entries.
// input is taken only between items; results pass through one output register.
// rst_n is synchronous, active low.
module rate_monotonic_tick_scheduler_top #(
  parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rmts_in_if.sink    in_ch,
  rmts_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [3:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  logic               mode_r;
  logic [3:0]         tcount_r;
  rmts_pkg::dp_cmd_t  cmd;
  rmts_pkg::dp_stat_t stat;
  logic [CNT_W-1:0]   cnt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      tcount_r <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        rmts_pkg::CFG_MODE:  mode_r <= cfg_wdata[0];
        rmts_pkg::CFG_COUNT: tcount_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rmts_ctrl #(.MAX_TASKS(MAX_TASKS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_command (in_ch.command),
    .task_count (tcount_r),
    .stat       (stat),
    .cmd        (cmd),
    .cnt        (cnt)
  );

  rmts_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cnt                 (cnt),
    .algorithm_mode      (mode_r),
    .ld_slot             (in_ch.task_slot),
    .ld_period           (in_ch.task_period),
    .ld_burst            (in_ch.task_burst),
    .ld_deadline         (in_ch.task_deadline),
    .ld_order            (in_ch.task_order),
    .out_ready           (out_ch.ready),
    .out_valid           (out_ch.valid),
    .out_result_kind     (out_ch.result_kind),
    .out_task_id         (out_ch.task_id),
    .out_idle            (out_ch.idle),
    .out_duration        (out_ch.duration),
    .out_outcome         (out_ch.outcome),
    .out_completed_count (out_ch.completed_count),
    .out_lost_count      (out_ch.lost_count),
    .out_killed_count    (out_ch.killed_count),
    .out_last            (out_ch.last)
  );

endmodule

### tb/tb.sv
module tb;

  localparam int NSLOT = rmts_pkg::MAX_TASKS_DEF;
  localparam int IDLE_RUN = NSLOT;
  // command code with no meaning, ignored by the block
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  slot;
    logic [15:0] period;
    logic [15:0] burst;
    logic [15:0] deadline;
    logic [7:0]  order;
  } stim_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  id;
    logic        idle;
    logic [31:0] dur;
    logic [1:0]  outc;
    logic [31:0] done_cnt;
    logic [31:0] lost_cnt;
    logic        killed;
    logic        last;
  } sched_res_t;

  typedef struct packed {
    stim_t      s;
    logic       typed;
    sched_res_t r;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_addr;
  logic [3:0] cfg_wdata;

  rmts_in_if  in_ch();
  rmts_out_if out_ch();

  rate_monotonic_tick_scheduler_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // scheduler shadow state
  logic        sh_mode;
  logic [3:0]  sh_count;
  logic [31:0] sh_time;
  logic [31:0] sh_seg_begin;
  int          sh_running;
  logic [15:0] sh_period [NSLOT];
  logic [15:0] sh_burst [NSLOT];
  logic [15:0] sh_deadline [NSLOT];
  logic [7:0]  sh_order [NSLOT];
  logic        sh_active [NSLOT];
  logic [15:0] sh_remain [NSLOT];
  logic [31:0] sh_due [NSLOT];
  logic [15:0] sh_countdown [NSLOT];
  logic [31:0] sh_done [NSLOT];
  logic [31:0] sh_missed [NSLOT];

  sched_res_t timeline_q[$];
  int  errors;
  bit  no_idle;
  bit  long_hold;

  function automatic void clear_run_state();
    sh_time = '0;
    sh_seg_begin = '0;
    sh_running = IDLE_RUN;
    for (int i = 0; i < NSLOT; i++) begin
      sh_active[i] = 1'b0;
      sh_remain[i] = '0;
      sh_due[i] = '0;
      sh_countdown[i] = '0;
      sh_done[i] = '0;
      sh_missed[i] = '0;
    end
  endfunction

  function automatic bit busy_job(int i);
    return sh_active[i] && sh_remain[i] != 0;
  endfunction

  function automatic void push_segment(logic [1:0] outc, logic last);
    sched_res_t r;
    r = '0;
    r.kind = rmts_pkg::KIND_SEGMENT;
    r.idle = (sh_running >= NSLOT);
    r.id = r.idle ? 3'd0 : sh_running[2:0];
    r.dur = sh_time - sh_seg_begin;
    r.outc = outc;
    r.last = last;
    timeline_q.push_back(r);
  endfunction

  // expected results of one accepted transfer
  function automatic void schedule_step(stim_t s);
    int n;
    int chosen;
    logic [1:0] outc;
    sched_res_t r;
    n = (sh_count > NSLOT) ? NSLOT : int'(sh_count);
    chosen = IDLE_RUN;
    case (s.cmd)
      rmts_pkg::CMD_LOAD: begin
        sh_period[s.slot] = s.period;
        sh_burst[s.slot] = s.burst;
        sh_deadline[s.slot] = s.deadline;
        sh_order[s.slot] = s.order;
      end
      rmts_pkg::CMD_TICK: begin
        // drop jobs at deadline
        for (int i = 0; i < n; i++)
          if (busy_job(i) && sh_due[i] == sh_time) begin
            sh_active[i] = 1'b0;
            if (sh_missed[i] != '1) sh_missed[i]++;
          end
        // releases
        for (int i = 0; i < n; i++) begin
          if (sh_countdown[i] == 0) begin
            sh_active[i] = 1'b1;
            sh_remain[i] = sh_burst[i];
            sh_due[i] = sh_time + 32'(sh_deadline[i]);
            sh_countdown[i] = (sh_period[i] == 0) ? 16'd0 : sh_period[i] - 16'd1;
          end else begin
            sh_countdown[i]--;
          end
        end
        // pick shortest period, then lower order, then lower slot
        if (sh_mode == 1'b0)
          for (int i = 0; i < n; i++) begin
            if (!busy_job(i)) continue;
            if (chosen == IDLE_RUN || sh_period[i] < sh_period[chosen] ||
                (sh_period[i] == sh_period[chosen] && sh_order[i] < sh_order[chosen]))
              chosen = i;
          end
        if (chosen != sh_running) begin
          if (sh_time != sh_seg_begin) begin
            outc = rmts_pkg::OUT_NONE;
            if (sh_running < NSLOT) begin
              if (!sh_active[sh_running])
                outc = (sh_remain[sh_running] == 0) ? rmts_pkg::OUT_FINISHED
                                                    : rmts_pkg::OUT_LOST;
              else
                outc = rmts_pkg::OUT_PREEMPTED;
            end
            push_segment(outc, 1'b0);
          end
          sh_running = chosen;
          sh_seg_begin = sh_time;
        end
        if (chosen < NSLOT) begin
          sh_remain[chosen]--;
          if (sh_remain[chosen] == 0) begin
            sh_active[chosen] = 1'b0;
            if (sh_done[chosen] != '1) sh_done[chosen]++;
          end
        end
        sh_time++;
      end
      rmts_pkg::CMD_FINISH: begin
        outc = rmts_pkg::OUT_NONE;
        if (sh_running < NSLOT && !sh_active[sh_running] && sh_remain[sh_running] == 0)
          outc = rmts_pkg::OUT_FINISHED;
        push_segment(outc, n == 0);
        for (int i = 0; i < n; i++) begin
          r = '0;
          r.kind = rmts_pkg::KIND_STATS;
          r.id = i[2:0];
          r.done_cnt = sh_done[i];
          r.lost_cnt = sh_missed[i];
          r.killed = busy_job(i);
          r.last = (i + 1 == n);
          timeline_q.push_back(r);
        end
        clear_run_state();
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // result side: stalls, long hold-off, comparison
  initial begin
    sched_res_t e;
    sched_res_t a;
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        stall = 400;
        long_hold = 1'b0;
      end else begin
        stall = draw_wait();
      end
      out_ch.ready = 1'b0;
      repeat (stall) @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      a = '{out_ch.result_kind, out_ch.task_id, out_ch.idle, out_ch.duration,
            out_ch.outcome, out_ch.completed_count, out_ch.lost_count,
            out_ch.killed_count, out_ch.last};
      if (timeline_q.size() == 0) begin
        $display("%0t unexpected result %0h", $time, a);
        errors++;
      end else begin
        e = timeline_q.pop_front();
        check_field("result_kind", 32'(e.kind), 32'(a.kind));
        check_field("task_id", 32'(e.id), 32'(a.id));
        check_field("idle", 32'(e.idle), 32'(a.idle));
        check_field("duration", e.dur, a.dur);
        check_field("outcome", 32'(e.outc), 32'(a.outc));
        check_field("completed_count", e.done_cnt, a.done_cnt);
        check_field("lost_count", e.lost_cnt, a.lost_cnt);
        check_field("killed_count", 32'(e.killed), 32'(a.killed));
        check_field("last", 32'(e.last), 32'(a.last));
      end
    end
  end

  // one input transfer; called at a falling edge
  task automatic send_item(stim_t s);
    in_ch.valid = 1'b0;
    repeat (draw_wait()) @(negedge clk);
    {in_ch.command, in_ch.task_slot, in_ch.task_period, in_ch.task_burst,
     in_ch.task_deadline, in_ch.task_order} = s;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    schedule_step(s);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (timeline_q.size() != 0) @(negedge clk);
    // covers a tick sweep and the clearing pass after a finish
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(logic addr, logic [3:0] val);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (addr == rmts_pkg::CFG_MODE) sh_mode = val[0];
    else sh_count = val;
  endtask

  function automatic stim_t well_formed_load(int slot);
    stim_t s;
    s.cmd = rmts_pkg::CMD_LOAD;
    s.slot = slot[2:0];
    s.period = 16'($urandom_range(1, 10));
    s.burst = 16'($urandom_range(0, 4));
    s.deadline = 16'($urandom_range(0, 12));
    s.order = 8'($urandom_range(0, 3));
    return s;
  endfunction

  task automatic random_run(int items);
    stim_t s;
    int p;
    for (int i = 0; i < NSLOT; i++) send_item(well_formed_load(i));
    for (int k = 0; k < items; k++) begin
      p = $urandom_range(0, 99);
      s = '0;
      if (p < 78) begin
        s.cmd = rmts_pkg::CMD_TICK;
        s.slot = 3'($urandom);
      end else if (p < 88) begin
        s = well_formed_load($urandom_range(0, NSLOT - 1));
        // sometimes the full field ranges
        if (p >= 85) begin
          s.period = 16'($urandom);
          s.burst = $urandom_range(0, 1) ? 16'($urandom_range(0, 6)) : 16'($urandom);
          s.deadline = 16'($urandom);
          s.order = 8'($urandom);
        end
      end else if (p < 92) begin
        s.cmd = CMD_SPARE;
        s = {s.cmd, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom)};
      end else begin
        s.cmd = rmts_pkg::CMD_FINISH;
      end
      send_item(s);
    end
    s = '0;
    s.cmd = rmts_pkg::CMD_FINISH;
    send_item(s);
  endtask

  dir_row_t dir_tab [23];

  initial begin
    sched_res_t fin_seg;
    sched_res_t got;
    int before_n;
    fin_seg = '0;
    fin_seg.kind = rmts_pkg::KIND_SEGMENT;
    fin_seg.idle = 1'b1;
    fin_seg.outc = rmts_pkg::OUT_NONE;

    dir_tab = '{
      '{'{rmts_pkg::CMD_LOAD,   3'd0, 16'd3,     16'd1,     16'd3,     8'd0},   1'b0, '0},
      '{'{rmts_pkg::CMD_LOAD,   3'd1, 16'd65535, 16'd65535, 16'd65535, 8'd255}, 1'b0, '0},
      '{'{rmts_pkg::CMD_LOAD,   3'd2, 16'd0,     16'd1,     16'd0,     8'd7},   1'b0, '0},
      '{'{rmts_pkg::CMD_LOAD,   3'd3, 16'd4,     16'd0,     16'd2,     8'd1},   1'b0, '0},
      '{'{rmts_pkg::CMD_LOAD,   3'd4, 16'd5,     16'd2,     16'd4,     8'd0},   1'b0, '0},
      '{'{rmts_pkg::CMD_LOAD,   3'd5, 16'd5,     16'd2,     16'd5,     8'd0},   1'b0, '0},
      '{'{rmts_pkg::CMD_LOAD,   3'd6, 16'd2,     16'd3,     16'd2,     8'd200}, 1'b0, '0},
      '{'{rmts_pkg::CMD_LOAD,   3'd7, 16'd6,     16'd1,     16'd1,     8'd9},   1'b0, '0},
      '{'{rmts_pkg::CMD_FINISH, 3'd0, 16'd0,     16'd0,     16'd0,     8'd0},   1'b1, fin_seg},
      '{'{rmts_pkg::CMD_TICK,   3'd0, 16'd0,     16'd0,     16'd0,     8'd0},   1'b0, '0},
      '{'{rmts_pkg::CMD_TICK,   3'd7, 16'hffff,  16'hffff,  16'hffff,  8'hff},  1'b0, '0},
      '{'{rmts_pkg::CMD_TICK,   3'd0, 16'd0,     16'd0,     16'd0,     8'd0},   1'b0, '0},
      '{'{rmts_pkg::CMD_TICK,   3'd0, 16'd0,     16'd0,     16'd0,     8'd0},   1'b0, '0},
      '{'{rmts_pkg::CMD_TICK,   3'd0, 16'd0,     16'd0,     16'd0,     8'd0},   1'b0, '0},
      '{'{CMD_SPARE,            3'd7, 16'hffff,  16'hffff,  16'hffff,  8'hff},  1'b0, '0},
      '{'{rmts_pkg::CMD_TICK,   3'd0, 16'd0,     16'd0,     16'd0,     8'd0},   1'b0, '0},
      '{'{rmts_pkg::CMD_LOAD,   3'd0, 16'd1,     16'd2,     16'd9,     8'd3},   1'b0, '0},
      '{'{rmts_pkg::CMD_TICK,   3'd0, 16'd0,     16'd0,     16'd0,     8'd0},   1'b0, '0},
      '{'{rmts_pkg::CMD_TICK,   3'd0, 16'd0,     16'd0,     16'd0,     8'd0},   1'b0, '0},
      '{'{rmts_pkg::CMD_TICK,   3'd0, 16'd0,     16'd0,     16'd0,     8'd0},   1'b0, '0},
      '{'{rmts_pkg::CMD_TICK,   3'd0, 16'd0,     16'd0,     16'd0,     8'd0},   1'b0, '0},
      '{'{rmts_pkg::CMD_FINISH, 3'd0, 16'd0,     16'd0,     16'd0,     8'd0},   1'b0, '0},
      '{'{rmts_pkg::CMD_FINISH, 3'd0, 16'd0,     16'd0,     16'd0,     8'd0},   1'b1, fin_seg}
    };

    errors = 0;
    no_idle = 1'b0;
    long_hold = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = rmts_pkg::CFG_MODE;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    {in_ch.command, in_ch.task_slot, in_ch.task_period, in_ch.task_burst,
     in_ch.task_deadline, in_ch.task_order} = '0;
    sh_mode = 1'b0;
    sh_count = 4'd1;
    for (int i = 0; i < NSLOT; i++) begin
      sh_period[i] = '0;
      sh_burst[i] = '0;
      sh_deadline[i] = '0;
      sh_order[i] = '0;
    end
    clear_run_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part over all entries
    write_reg(rmts_pkg::CFG_MODE, 4'd0);
    write_reg(rmts_pkg::CFG_COUNT, 4'd8);
    foreach (dir_tab[k]) begin
      // typed rows start from an empty queue so the index stays put
      if (dir_tab[k].typed)
        while (timeline_q.size() != 0) @(negedge clk);
      before_n = timeline_q.size();
      send_item(dir_tab[k].s);
      if (dir_tab[k].typed) begin
        got = timeline_q[before_n];
        if (got != dir_tab[k].r) begin
          $display("%0t mismatch final segment expected %0h actual %0h",
                   $time, dir_tab[k].r, got);
          errors++;
        end
      end
    end
    wait_drained();

    // random runs across register settings
    write_reg(rmts_pkg::CFG_COUNT, 4'd3);
    random_run(36);
    wait_drained();

    // result side holds off while ticks keep coming
    write_reg(rmts_pkg::CFG_COUNT, 4'd8);
    long_hold = 1'b1;
    random_run(36);
    wait_drained();

    write_reg(rmts_pkg::CFG_MODE, 4'd1);
    write_reg(rmts_pkg::CFG_COUNT, 4'd4);
    random_run(30);
    wait_drained();

    write_reg(rmts_pkg::CFG_MODE, 4'd0);
    write_reg(rmts_pkg::CFG_COUNT, 4'd0);
    random_run(16);
    wait_drained();

    write_reg(rmts_pkg::CFG_COUNT, 4'd15);
    no_idle = 1'b1;
    random_run(36);
    wait_drained();
    no_idle = 1'b0;

    write_reg(rmts_pkg::CFG_COUNT, 4'd1);
    random_run(30);
    wait_drained();

    write_reg(rmts_pkg::CFG_COUNT, 4'd8);
    random_run(36);
    wait_drained();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
